// File: rtl/lcgd_pkg.sv
// shared types and constants for the lcg xor letter decoder
// no dependencies; imported by every module of the block
`default_nettype none

package lcgd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 1'b1;

  localparam logic [31:0] MULT_RESET = 32'd16811;
  localparam logic [31:0] INCR_RESET = 32'd7;

  // generator modulus, 2^31 - 1
  localparam logic [31:0] LCG_MODULUS = 32'h7FFF_FFFF;

  // character codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] PAIR_RADIX   = 8'd10;

  // decoupling queue depth, at least two for full rate
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_SEED,
    TOK_DATA
  } tok_kind_e;

  // one classified item handed from front to back
  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] byte_val;
    logic       corrupt;
    logic       last;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/lcgd_front.sv
// front part: accepts characters, pairs digits, tracks the seed and emits tokens
// depends on lcgd_pkg
`default_nettype none

module lcgd_front
  import lcgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_message_i,
  input  wire queue_stat_t q_stat_i,
  output      logic        in_stall_o,
  output      logic        push_o,
  output      token_t      token_o
);

  logic       seed_taken_q, seed_taken_d;
  logic       pend_q, pend_d;
  logic [7:0] low_q, low_d;
  logic       accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    logic       blank;
    logic       letter;
    logic       dec;
    logic       corrupt;
    logic [7:0] b;
    logic [7:0] diff;
    logic [7:0] hi_part;

    blank   = (char_code_i == CHAR_SPACE) ||
              (char_code_i >= CHAR_TAB && char_code_i <= CHAR_CR);
    letter  = (char_code_i >= CHAR_UPPER_A && char_code_i <= CHAR_UPPER_Z) ||
              (char_code_i >= CHAR_LOWER_A && char_code_i <= CHAR_LOWER_Z);
    diff    = char_code_i - CHAR_UPPER_A;
    hi_part = diff * PAIR_RADIX;
    dec     = 1'b0;
    corrupt = 1'b0;
    b       = char_code_i;
    pend_d  = pend_q;
    low_d   = low_q;

    if (!blank) begin
      if (pend_q) begin
        b      = low_q + hi_part;
        dec    = 1'b1;
        pend_d = 1'b0;
        low_d  = '0;
      end else if (letter) begin
        b   = char_code_i;
        dec = 1'b1;
      end else begin
        low_d  = char_code_i - CHAR_ZERO;
        pend_d = 1'b1;
      end
    end

    // message closes inside a pair: partial byte is emitted and flagged corrupt
    if (end_of_message_i && pend_d) begin
      b       = low_d;
      dec     = 1'b1;
      corrupt = 1'b1;
      pend_d  = 1'b0;
    end

    seed_taken_d = seed_taken_q || dec;
    if (end_of_message_i) begin
      seed_taken_d = 1'b0;
      pend_d       = 1'b0;
      low_d        = '0;
    end

    if (!dec) begin
      token_o.kind = TOK_NONE;
    end else if (!seed_taken_q) begin
      token_o.kind = TOK_SEED;
    end else begin
      token_o.kind = TOK_DATA;
    end
    token_o.byte_val = b;
    token_o.corrupt  = corrupt;
    token_o.last     = end_of_message_i;

    push_o = accept && (dec || end_of_message_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_taken_q <= 1'b0;
      pend_q       <= 1'b0;
      low_q        <= '0;
    end else if (accept) begin
      seed_taken_q <= seed_taken_d;
      pend_q       <= pend_d;
      low_q        <= low_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcgd_queue.sv
// short token queue between the front and back parts
// depends on lcgd_pkg
`default_nettype none

module lcgd_queue
  import lcgd_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire token_t      token_i,
  input  wire logic        pop_i,
  output      token_t      token_o,
  output      queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  token_t          slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign token_o      = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcgd_back.sv
// back part: generator state, xor of data bytes and the output register
// depends on lcgd_pkg
`default_nettype none

module lcgd_back
  import lcgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_wr_t     cfg_i,
  input  wire token_t      token_i,
  input  wire queue_stat_t q_stat_i,
  output      logic        pop_o,
  input  wire logic        out_stall_i,
  output      logic        out_valid_o,
  output      logic [7:0]  plain_byte_o,
  output      logic        has_data_o,
  output      logic        corrupt_o,
  output      logic        last_of_message_o
);

  logic [31:0] mult_q, incr_q;
  logic [30:0] state_q;
  logic [30:0] state_next;
  logic        out_valid_q;
  logic        emits;

  // (a*state + c) mod 2^32, then mod 2^31-1 by folding the top bit
  always_comb begin
    logic [31:0] prod;
    logic [31:0] sum;
    logic [31:0] fold;
    prod = mult_q * {1'b0, state_q};
    sum  = prod + incr_q;
    fold = {1'b0, sum[30:0]} + {31'b0, sum[31]};
    if (fold >= LCG_MODULUS) begin
      fold = fold - LCG_MODULUS;
    end
    state_next = fold[30:0];
  end

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign emits = (token_i.kind == TOK_DATA) || token_i.last;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RESET;
      incr_q <= INCR_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MULTIPLIER: mult_q <= cfg_i.data;
        CFG_INCREMENT:  incr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (token_i.last) begin
          state_q <= '0;
        end else if (token_i.kind == TOK_SEED) begin
          state_q <= {23'b0, token_i.byte_val};
        end else if (token_i.kind == TOK_DATA) begin
          state_q <= state_next;
        end
        out_valid_q <= emits;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emits) begin
      has_data_o        <= (token_i.kind == TOK_DATA);
      plain_byte_o      <= (token_i.kind == TOK_DATA) ?
                           (token_i.byte_val ^ state_next[7:0]) : 8'h00;
      corrupt_o         <= token_i.corrupt;
      last_of_message_o <= token_i.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcg_xor_letter_decoder.sv
// top level of the lcg xor letter decoder: front, token queue and back part
// depends on lcgd_pkg, lcgd_front, lcgd_queue, lcgd_back
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o    | char_code_i, end_of_message_i
//   out     | output    | out_valid_o / out_stall_i  | plain_byte_o, has_data_o,
//           |           |                            | corrupt_o, last_of_message_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one character per cycle while out_stall_i is low; a result goes via the queue and output register
// the rate is set by the combinational generator update in the back part
//   (32x32 multiply, add, fold-and-subtract mod 2^31-1)
// reset restores multiplier 16811 and increment 7 and clears all message state
// in_stall_o rises only when the token queue is full, i.e. when the output is stalled
// cfg writes are always taken (cfg_ready_o tied high)
`default_nettype none

module lcg_xor_letter_decoder
  import lcgd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // character transactions
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 end_of_message_i,
  // result transactions
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [7:0]           plain_byte_o,
  output      logic                 has_data_o,
  output      logic                 corrupt_o,
  output      logic                 last_of_message_o,
  // register writes
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  queue_stat_t q_stat;
  token_t      push_token;
  token_t      head_token;
  logic        push;
  logic        pop;
  cfg_wr_t     cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // classify characters, resolve digit pairs and seed position
  lcgd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .char_code_i      (char_code_i),
    .end_of_message_i (end_of_message_i),
    .q_stat_i         (q_stat),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .token_o          (push_token)
  );

  // decouples front acceptance from output stalls
  lcgd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_token),
    .pop_i   (pop),
    .token_o (head_token),
    .stat_o  (q_stat)
  );

  // generator update and output register
  lcgd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_wr),
    .token_i           (head_token),
    .q_stat_i          (q_stat),
    .pop_o             (pop),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .plain_byte_o      (plain_byte_o),
    .has_data_o        (has_data_o),
    .corrupt_o         (corrupt_o),
    .last_of_message_o (last_of_message_o)
  );

`ifndef NO_ASSERTIONS
  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("token queue overflow");

  // queue never read while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("token queue underflow");

  // a result without data is always a bare end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> (last_of_message_o && plain_byte_o == 8'h00))
    else $error("dataless result is not an end marker");

  // a corrupt result only closes a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && corrupt_o) |-> last_of_message_o)
    else $error("corrupt flag outside end of message");
`endif

endmodule

`default_nettype wire
